// ===== src/ps2ht_pkg.sv =====
// shared types and constants for the ps/2 host transceiver with receive fifo
`timescale 1ns / 1ps

package ps2ht_pkg;

    // receive fifo geometry
    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // width of the reported fifo level field
    localparam int LEVEL_W = 5;

    // item kinds on the input channel
    typedef enum logic [1:0] {
        KIND_EDGE = 2'd0,
        KIND_SEND = 2'd1,
        KIND_POP  = 2'd2
    } t_kind;

    // frame positions
    localparam logic [3:0] POS_IDLE      = 4'd0;
    localparam logic [3:0] POS_START     = 4'd1;
    localparam logic [3:0] POS_DATA_LAST = 4'd8;
    localparam logic [3:0] RX_FIRST      = 4'd2;
    localparam logic [3:0] RX_LAST       = 4'd9;
    localparam logic [3:0] POS_PARITY    = 4'd9;
    localparam logic [3:0] POS_STOP      = 4'd10;
    localparam logic [3:0] POS_ACK       = 4'd11;
    localparam logic [3:0] POS_FRAME_END = 4'd11;

    // request from the link engine to the fifo
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] wdata;
    } t_fifo_req;

    // link status after the current word
    typedef struct packed {
        logic line_low;
        logic sending;
        logic rejected;
        logic got;
        logic ovf;
    } t_link_stat;

endpackage

// ===== src/ps2_host_transceiver_fifo_top.sv =====
// top level of the ps/2 host transceiver with receive fifo
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+-----------------------------------------------
//  in      | i_in_valid  | o_in_ready  | i_kind, i_data_line, i_tx_byte
//  out     | o_out_valid | i_out_ready | o_data_drive_low, o_send_busy, o_send_rejected,
//          |             |             | o_byte_received, o_overflow, o_pop_valid,
//          |             |             | o_pop_byte, o_fifo_level
//
// one word in, one word out; a word can be taken every cycle while i_out_ready does not stall
// a word passes through the input register, then the frame/fifo update into the result register
// the result register holds while i_out_ready is low; the input register keeps taking
// a word as long as the result register drains or is empty in the same cycle
// synchronous active-low reset; no clearing pass, fifo storage is unset until written
`timescale 1ns / 1ps

module ps2_host_transceiver_fifo_top
    import ps2ht_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_kind,
    input  logic               i_data_line,
    input  logic [7:0]         i_tx_byte,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_data_drive_low,
    output logic               o_send_busy,
    output logic               o_send_rejected,
    output logic               o_byte_received,
    output logic               o_overflow,
    output logic               o_pop_valid,
    output logic [7:0]         o_pop_byte,
    output logic [LEVEL_W-1:0] o_fifo_level
);

    // input register
    logic       r_in_valid;
    logic [1:0] r_kind;
    logic       r_level;
    logic [7:0] r_tx_byte;

    // result register (pop byte register sits in the fifo)
    logic               r_out_valid;
    logic               r_line_low;
    logic               r_busy;
    logic               r_rejected;
    logic               r_got;
    logic               r_ovf;
    logic               r_pop_valid;
    logic [LEVEL_W-1:0] r_fifo_level;

    logic             advance;
    logic             fire;
    logic             fifo_full;
    logic             pop_valid;
    logic [CNT_W-1:0] count_next;
    t_fifo_req        fifo_req;
    t_link_stat       link_stat;

    // result slot is free or being emptied this cycle
    assign advance    = !r_out_valid || i_out_ready;
    // the buffered word moves into the result register
    assign fire       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // payload of the input register, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_kind    <= i_kind;
            r_level   <= i_data_line;
            r_tx_byte <= i_tx_byte;
        end
    end

    ps2ht_link u_link (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (fire),
        .i_kind      (t_kind'(r_kind)),
        .i_level     (r_level),
        .i_tx_byte   (r_tx_byte),
        .i_fifo_full (fifo_full),
        .o_req       (fifo_req),
        .o_stat      (link_stat)
    );

    ps2ht_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (fire),
        .i_req        (fifo_req),
        .o_full       (fifo_full),
        .o_pop_valid  (pop_valid),
        .o_pop_byte   (o_pop_byte),
        .o_count_next (count_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // status taken after this word's update
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_line_low   <= link_stat.line_low;
            r_busy       <= link_stat.sending;
            r_rejected   <= link_stat.rejected;
            r_got        <= link_stat.got;
            r_ovf        <= link_stat.ovf;
            r_pop_valid  <= pop_valid;
            r_fifo_level <= LEVEL_W'(count_next);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_data_drive_low = r_line_low;
    assign o_send_busy      = r_busy;
    assign o_send_rejected  = r_rejected;
    assign o_byte_received  = r_got;
    assign o_overflow       = r_ovf;
    assign o_pop_valid      = r_pop_valid;
    assign o_fifo_level     = r_fifo_level;

endmodule

// ===== src/ps2ht_link.sv =====
// ps/2 frame engine: receive shifter and host send sequencer
`timescale 1ns / 1ps

module ps2ht_link
    import ps2ht_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_kind      i_kind,
    input  logic       i_level,
    input  logic [7:0] i_tx_byte,
    input  logic       i_fifo_full,
    output t_fifo_req  o_req,
    output t_link_stat o_stat
);

    logic [3:0] r_pos;
    logic       r_parity;
    logic [7:0] r_shift;
    logic       r_sending;
    logic       r_line_low;

    logic [3:0] n_pos;
    logic       n_parity;
    logic [7:0] n_shift;
    logic       n_sending;
    logic       n_line_low;

    logic [3:0] pos_w;
    logic [2:0] tx_idx;
    logic [2:0] rx_idx;
    logic       rejected;
    logic       got;
    logic       ovf;
    logic       push;
    logic       pop;

    assign tx_idx = 3'(r_pos - POS_START);
    assign rx_idx = 3'(r_pos - RX_FIRST);

    always_comb begin
        n_pos      = r_pos;
        n_parity   = r_parity;
        n_shift    = r_shift;
        n_sending  = r_sending;
        n_line_low = r_line_low;
        pos_w      = r_pos;
        rejected   = 1'b0;
        got        = 1'b0;
        ovf        = 1'b0;
        push       = 1'b0;
        pop        = 1'b0;
        case (i_kind)
            KIND_EDGE: begin
                if (r_sending) begin
                    case (r_pos) inside
                        POS_PARITY: n_line_low = r_parity;
                        POS_STOP:   n_line_low = 1'b0;
                        POS_ACK: begin
                            n_shift    = 8'd0;
                            pos_w      = POS_IDLE;
                            n_sending  = 1'b0;
                            n_line_low = 1'b0;
                        end
                        [POS_START:POS_DATA_LAST]: begin
                            if (r_shift[tx_idx]) begin
                                n_line_low = 1'b0;
                                n_parity   = ~r_parity;
                            end else begin
                                n_line_low = 1'b1;
                            end
                        end
                        default: n_line_low = 1'b0;
                    endcase
                end else begin
                    case (r_pos) inside
                        [RX_FIRST:RX_LAST]: begin
                            if (i_level) begin
                                n_shift[rx_idx] = 1'b1;
                            end
                        end
                        POS_FRAME_END: begin
                            if (!i_fifo_full) begin
                                push = 1'b1;
                                got  = 1'b1;
                            end else begin
                                ovf = 1'b1;
                            end
                            n_shift = 8'd0;
                            pos_w   = POS_IDLE;
                        end
                        default: ;
                    endcase
                end
                n_pos = pos_w + 4'd1;
            end
            KIND_SEND: begin
                if (r_sending) begin
                    rejected = 1'b1;
                end else begin
                    n_pos      = POS_START;
                    n_parity   = 1'b0;
                    n_shift    = i_tx_byte;
                    n_sending  = 1'b1;
                    n_line_low = 1'b1;
                end
            end
            KIND_POP: pop = 1'b1;
            default: ;
        endcase
    end

    assign o_req  = '{push: push, pop: pop, wdata: r_shift};
    assign o_stat = '{line_low: n_line_low, sending: n_sending, rejected: rejected,
                      got: got, ovf: ovf};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= POS_START;
            r_parity   <= 1'b0;
            r_shift    <= 8'd0;
            r_sending  <= 1'b0;
            r_line_low <= 1'b0;
        end else if (i_en) begin
            r_pos      <= n_pos;
            r_parity   <= n_parity;
            r_shift    <= n_shift;
            r_sending  <= n_sending;
            r_line_low <= n_line_low;
        end
    end

    // host only pulls data low while a send is running
    a_line_only_when_sending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sending |-> !r_line_low)
        else $error("data line driven low with no send in progress");

    // position restarts at one after a frame, never sits at zero
    a_pos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos != POS_IDLE)
        else $error("frame position at zero");

    // an accepted send starts by driving the start bit
    a_send_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_kind == KIND_SEND && !r_sending) |=> (r_sending && r_line_low))
        else $error("send request did not start a frame");

endmodule

// ===== src/ps2ht_fifo.sv =====
// receive byte fifo with registered pop data
`timescale 1ns / 1ps

module ps2ht_fifo
    import ps2ht_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_fifo_req        i_req,
    output logic             o_full,
    output logic             o_pop_valid,
    output logic [7:0]       o_pop_byte,
    output logic [CNT_W-1:0] o_count_next
);

    logic [7:0]       r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_pop_byte;

    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign do_push = i_req.push && !o_full;
    assign do_pop  = i_req.pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            n_count  = r_count + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            n_count  = r_count - 1'b1;
        end
    end

    assign o_pop_valid  = do_pop;
    assign o_count_next = n_count;
    assign o_pop_byte   = r_pop_byte;

    always_ff @(posedge i_clk) begin
        if (i_en && do_push) begin
            r_mem[r_wr_ptr] <= i_req.wdata;
        end
        if (i_en) begin
            r_pop_byte <= do_pop ? r_mem[r_rd_ptr] : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else if (i_en) begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("fifo count above depth");

    // the link engine must turn a full fifo into an overflow, not a push
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_req.push) |-> !o_full)
        else $error("push into full fifo");

    a_empty_pop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_req.pop && r_count == '0) |=> (r_pop_byte == 8'd0 && r_count == '0))
        else $error("pop from empty fifo returned data");

endmodule

// ===== dv/ps2_host_transceiver_fifo_top_tb.sv =====
// self-checking testbench for the ps/2 host transceiver with receive fifo
`timescale 1ns / 1ps

module ps2_host_transceiver_fifo_top_tb;
    import ps2ht_pkg::*;

    // the one kind value the block has no use for
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int N_DIRECTED     = 25;
    localparam int RANDOM_WORDS   = 1000;
    // cycles with no word moving on either channel before the run is given up
    localparam int WATCHDOG_LIMIT = 2000;
    // covers the input and result registers, plus margin, to catch stray result words after the last one
    localparam int DRAIN_CYCLES   = 8;

    // one result word as the block reports it
    typedef struct packed {
        logic               drive_low;
        logic               busy;
        logic               rejected;
        logic               got;
        logic               ovf;
        logic               pop_valid;
        logic [7:0]         pop_byte;
        logic [LEVEL_W-1:0] level;
    } t_status_word;

    // one row of the directed table; typed rows carry their own expected status
    typedef struct {
        logic [1:0]   kind;
        logic         line;
        logic [7:0]   txb;
        logic         typed;
        t_status_word exp;
    } t_stim_row;

    // dut ports, every input driven to a known value from time zero
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_kind      = KIND_EDGE;
    logic               i_data_line = 1'b0;
    logic [7:0]         i_tx_byte   = 8'h00;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_data_drive_low;
    logic               o_send_busy;
    logic               o_send_rejected;
    logic               o_byte_received;
    logic               o_overflow;
    logic               o_pop_valid;
    logic [7:0]         o_pop_byte;
    logic [LEVEL_W-1:0] o_fifo_level;

    ps2_host_transceiver_fifo_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_data_line      (i_data_line),
        .i_tx_byte        (i_tx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_data_drive_low (o_data_drive_low),
        .o_send_busy      (o_send_busy),
        .o_send_rejected  (o_send_rejected),
        .o_byte_received  (o_byte_received),
        .o_overflow       (o_overflow),
        .o_pop_valid      (o_pop_valid),
        .o_pop_byte       (o_pop_byte),
        .o_fifo_level     (o_fifo_level)
    );

    always #6 i_clk = ~i_clk;

    // link and fifo state as the predictor sees it after every accepted word
    logic [3:0]  frame_pos      = POS_START;
    logic [3:0]  tx_ones        = 4'd0;
    logic [7:0]  frame_shift    = 8'h00;
    logic        tx_active      = 1'b0;
    logic        host_drive_low = 1'b0;
    logic [7:0]  rx_bytes [FIFO_DEPTH];
    int          rx_wr          = 0;
    int          rx_rd          = 0;
    int          rx_fill        = 0;

    t_status_word expected_status [$];
    int           status_errors = 0;
    int           words_applied = 0;
    int           send_idle_pct = 23;
    int           recv_idle_pct = 50;
    int           quiet_cycles  = 0;

    // advance the link state by one word and return the status the block should report
    function automatic t_status_word predict_status(input logic [1:0] kind, input logic line,
                                                    input logic [7:0] txb);
        t_status_word s;
        logic [3:0]   pos;
        s   = '0;
        pos = frame_pos;
        case (kind)
            KIND_EDGE: begin
                if (tx_active) begin
                    if (pos == POS_PARITY) begin
                        // odd parity: an odd count of ones means a low parity bit
                        host_drive_low = tx_ones[0];
                    end else if (pos == POS_STOP) begin
                        host_drive_low = 1'b0;
                    end else if (pos == POS_ACK) begin
                        // line released at the ack edge, device ack is not looked at
                        frame_shift    = 8'h00;
                        pos            = POS_IDLE;
                        tx_active      = 1'b0;
                        host_drive_low = 1'b0;
                    end else if (pos >= POS_START && pos <= POS_DATA_LAST) begin
                        if (frame_shift[3'(pos - POS_START)]) begin
                            host_drive_low = 1'b0;
                            tx_ones        = tx_ones + 4'd1;
                        end else begin
                            host_drive_low = 1'b1;
                        end
                    end else begin
                        host_drive_low = 1'b0;
                    end
                end else begin
                    if (pos >= RX_FIRST && pos <= RX_LAST) begin
                        if (line) frame_shift[3'(pos - RX_FIRST)] = 1'b1;
                    end else if (pos == POS_FRAME_END) begin
                        if (rx_fill < FIFO_DEPTH) begin
                            rx_bytes[rx_wr] = frame_shift;
                            rx_wr           = (rx_wr + 1) % FIFO_DEPTH;
                            rx_fill++;
                            s.got = 1'b1;
                        end else begin
                            s.ovf = 1'b1;
                        end
                        frame_shift = 8'h00;
                        pos         = POS_IDLE;
                    end
                end
                frame_pos = pos + 4'd1;
            end
            KIND_SEND: begin
                if (tx_active) begin
                    s.rejected = 1'b1;
                end else begin
                    // any partial received frame is thrown away here
                    frame_pos      = POS_START;
                    tx_ones        = 4'd0;
                    frame_shift    = txb;
                    tx_active      = 1'b1;
                    host_drive_low = 1'b1;
                end
            end
            KIND_POP: begin
                if (rx_fill > 0) begin
                    s.pop_valid = 1'b1;
                    s.pop_byte  = rx_bytes[rx_rd];
                    rx_rd       = (rx_rd + 1) % FIFO_DEPTH;
                    rx_fill--;
                end
            end
            default: ;
        endcase
        s.drive_low = host_drive_low;
        s.busy      = tx_active;
        s.level     = LEVEL_W'(rx_fill);
        return s;
    endfunction

    function automatic string fmt_status(input t_status_word s);
        return $sformatf("low=%0b busy=%0b rej=%0b got=%0b ovf=%0b pv=%0b byte=%02h lvl=%0d",
                         s.drive_low, s.busy, s.rejected, s.got, s.ovf, s.pop_valid,
                         s.pop_byte, s.level);
    endfunction

    // offer one word, hold it until taken, then log what it should produce
    task automatic put_word(input logic [1:0] kind, input logic line, input logic [7:0] txb,
                            input logic typed, input t_status_word typed_exp);
        t_status_word pred;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_data_line <= line;
        i_tx_byte   <= txb;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        pred = predict_status(kind, line, txb);
        expected_status.push_back(typed ? typed_exp : pred);
        // ignored words (unused kind, refused send, pop of an empty fifo) are not counted
        if (kind != KIND_UNUSED && !pred.rejected && !(kind == KIND_POP && !pred.pop_valid))
            words_applied++;
    endtask

    // result side back-pressure
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker: every result word is matched in order against the oldest expectation
    always @(posedge i_clk) begin
        t_status_word seen;
        t_status_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = '{o_data_drive_low, o_send_busy, o_send_rejected, o_byte_received,
                     o_overflow, o_pop_valid, o_pop_byte, o_fifo_level};
            if (expected_status.size() == 0) begin
                status_errors++;
                if (status_errors <= 10)
                    $display("unexpected result word: %s", fmt_status(seen));
            end else begin
                want = expected_status.pop_front();
                if (seen !== want) begin
                    status_errors++;
                    if (status_errors <= 10)
                        $display("result mismatch\n  expected %s\n  actual   %s",
                                 fmt_status(want), fmt_status(seen));
                end
            end
        end
    end

    // watchdog: gives up when neither channel moves a word for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("ps2_host_transceiver_fifo_top_tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        t_stim_row  directed_rows [N_DIRECTED];
        int         random_base;
        int         progress;
        int         pick;
        logic       filling;
        logic       broken;
        logic       lvl;
        logic [7:0] frame_byte;

        // directed table: empty pop and the unused kind straight after reset, a full
        // frame of ones, its pop, a reception cut short by a send, a refused send while
        // busy, then the first data edges of the send of all zeros
        directed_rows = '{
            '{KIND_POP,    1'b0, 8'h00, 1'b1, '0},
            '{KIND_UNUSED, 1'b1, 8'hff, 1'b1, '0},
            '{KIND_EDGE,   1'b1, 8'h00, 1'b0, '0},
            '{KIND_EDGE,   1'b1, 8'hff, 1'b0, '0},
            '{KIND_EDGE,   1'b1, 8'h00, 1'b0, '0},
            '{KIND_EDGE,   1'b1, 8'hff, 1'b0, '0},
            '{KIND_EDGE,   1'b1, 8'h00, 1'b0, '0},
            '{KIND_EDGE,   1'b1, 8'hff, 1'b0, '0},
            '{KIND_EDGE,   1'b1, 8'h00, 1'b0, '0},
            '{KIND_EDGE,   1'b1, 8'hff, 1'b0, '0},
            '{KIND_EDGE,   1'b1, 8'h00, 1'b0, '0},
            '{KIND_EDGE,   1'b1, 8'hff, 1'b0, '0},
            '{KIND_EDGE,   1'b1, 8'h00, 1'b0, '0},
            '{KIND_POP,    1'b0, 8'h00, 1'b1,
              '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'hff, 5'd0}},
            '{KIND_EDGE,   1'b0, 8'h00, 1'b0, '0},
            '{KIND_EDGE,   1'b1, 8'h00, 1'b0, '0},
            '{KIND_SEND,   1'b0, 8'h00, 1'b1,
              '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0}},
            '{KIND_SEND,   1'b1, 8'hff, 1'b1,
              '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0}},
            '{KIND_EDGE,   1'b0, 8'hff, 1'b0, '0},
            '{KIND_EDGE,   1'b1, 8'h00, 1'b0, '0},
            '{KIND_EDGE,   1'b0, 8'hff, 1'b0, '0},
            '{KIND_EDGE,   1'b1, 8'h00, 1'b0, '0},
            '{KIND_EDGE,   1'b0, 8'hff, 1'b0, '0},
            '{KIND_EDGE,   1'b1, 8'h00, 1'b0, '0},
            '{KIND_EDGE,   1'b0, 8'hff, 1'b0, '0}
        };

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            put_word(directed_rows[r].kind, directed_rows[r].line, directed_rows[r].txb,
                     directed_rows[r].typed, directed_rows[r].exp);

        // random traffic; the fifo alternates between a filling spell, which runs it
        // into overflow, and a draining spell, which runs it dry and pops it empty
        random_base = words_applied;
        filling     = 1'b1;
        while (words_applied - random_base < RANDOM_WORDS) begin
            progress = words_applied - random_base;
            if (progress < RANDOM_WORDS / 3) begin
                send_idle_pct = 23;
                recv_idle_pct = 50;
            end else if (progress < 2 * RANDOM_WORDS / 3) begin
                send_idle_pct = 50;
                recv_idle_pct = 23;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (filling && rx_fill == FIFO_DEPTH && $urandom_range(2) == 0)
                filling = 1'b0;
            else if (!filling && rx_fill == 0)
                filling = 1'b1;

            pick = $urandom_range(99);
            if (tx_active) begin
                // mostly edges to finish the send, with refused sends, unused kinds and pops mixed in
                if (pick < 4)
                    put_word(KIND_SEND, $urandom_range(1), $urandom_range(255), 1'b0, '0);
                else if (pick < 8)
                    put_word(KIND_UNUSED, $urandom_range(1), $urandom_range(255), 1'b0, '0);
                else if (pick < 14)
                    put_word(KIND_POP, $urandom_range(1), $urandom_range(255), 1'b0, '0);
                else
                    put_word(KIND_EDGE, $urandom_range(1), $urandom_range(255), 1'b0, '0);
            end else if (pick < (filling ? 60 : 25)) begin
                // device frame: start 0, data lsb first, odd parity, stop 1; it picks up
                // from wherever the position counter stands so stray edges realign
                frame_byte = $urandom_range(255);
                broken     = ($urandom_range(9) == 0);
                do begin
                    case (frame_pos)
                        POS_START:     lvl = 1'b0;
                        POS_STOP:      lvl = ~^frame_byte;  // parity slot on receive
                        POS_FRAME_END: lvl = 1'b1;
                        default:       lvl = frame_byte[3'(frame_pos - RX_FIRST)];
                    endcase
                    if (broken && $urandom_range(3) == 0)
                        lvl = $urandom_range(1);
                    if ($urandom_range(19) == 0)
                        put_word(KIND_POP, $urandom_range(1), $urandom_range(255), 1'b0, '0);
                    put_word(KIND_EDGE, lvl, $urandom_range(255), 1'b0, '0);
                    // a send in mid frame abandons the reception
                    if (broken && frame_pos != POS_START && $urandom_range(7) == 0)
                        put_word(KIND_SEND, $urandom_range(1), $urandom_range(255),
                                 1'b0, '0);
                end while (frame_pos != POS_START && !tx_active);
            end else if (pick < (filling ? 75 : 40)) begin
                put_word(KIND_SEND, $urandom_range(1), $urandom_range(255), 1'b0, '0);
            end else if (pick < 93) begin
                repeat (filling ? 1 : $urandom_range(1, 4))
                    put_word(KIND_POP, $urandom_range(1), $urandom_range(255), 1'b0, '0);
            end else if ($urandom_range(1) == 0) begin
                put_word(KIND_UNUSED, $urandom_range(1), $urandom_range(255), 1'b0, '0);
            end else begin
                // lone edge that knocks the frame position out of step
                put_word(KIND_EDGE, $urandom_range(1), $urandom_range(255), 1'b0, '0);
            end
        end

        @(negedge i_clk);
        i_in_valid    <= 1'b0;
        recv_idle_pct = 0;

        // the watchdog bounds this wait
        while (expected_status.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (status_errors == 0) begin
            $display("ps2_host_transceiver_fifo_top_tb OK");
        end else begin
            $display("ps2_host_transceiver_fifo_top_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== ps2_host_transceiver_fifo_top.f =====
src/ps2ht_pkg.sv
src/ps2ht_link.sv
src/ps2ht_fifo.sv
src/ps2_host_transceiver_fifo_top.sv
dv/ps2_host_transceiver_fifo_top_tb.sv
